// ===== design/savb_pkg.sv =====
// ----------------------------------------------------------------------------
// savb_pkg
// Widths, constants and helper types for the signed vector angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package savb_pkg;
	localparam int CW       = 16;                 // vector component width
	localparam int AFB      = 13;                 // angle fraction bits
	localparam int AW       = AFB + 3;            // angle width
	localparam int IN_W     = 9 * CW;
	localparam int IN_TW    = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TW   = ((AW + 7) / 8) * 8;
	localparam int PW       = 2 * CW;             // single product
	localparam int XW       = 2 * CW + 1;         // cross term
	localparam int DW       = 2 * CW + 2;         // dot product
	localparam int MW       = 2 * CW + 1;         // magnitudes
	localparam int TPW      = CW + XW;            // normal times cross term
	localparam int TW       = TPW + 2;            // triple product sum
	localparam int NW       = 30;                 // normalized magnitude
	localparam int SQW      = 2 * NW + 2;         // sum of squares
	localparam int RW       = NW + 1;             // root width
	localparam int SQ_STEPS = NW + 1;
	localparam int CXW      = NW + 4;             // cordic x/y width
	localparam int ZW       = 34;                 // cordic angle, Q30
	localparam int CORDIC_STEPS = 30;
	localparam int SH       = 30 - AFB;
	localparam int SHW      = $clog2(MW - NW + 1);

	localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'd3373259426);
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'd1686629713);
	localparam logic signed [ZW-1:0] RND_Q30     = ZW'(64'd1 << (SH - 1));
	localparam logic [AW-1:0] HALF_PI_ANGLE = AW'((64'd1686629713 + (64'd1 << (SH - 1))) >> SH);
	localparam logic [AW-1:0] PI_ANGLE      = AW'((64'd3373259426 + (64'd1 << (SH - 1))) >> SH);

	typedef struct packed {
		logic neg;
		logic degen;
	} flags_t;

	typedef struct packed {
		flags_t                  flags;
		logic signed [CXW-1:0]   x;
	} sqrt_side_t;

	function automatic logic signed [ZW-1:0] arc_step(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = ZW'(64'd843314857);
			1:  r = ZW'(64'd497837829);
			2:  r = ZW'(64'd263043837);
			3:  r = ZW'(64'd133525159);
			4:  r = ZW'(64'd67021687);
			5:  r = ZW'(64'd33543516);
			6:  r = ZW'(64'd16775851);
			7:  r = ZW'(64'd8388437);
			8:  r = ZW'(64'd4194283);
			9:  r = ZW'(64'd2097149);
			10: r = ZW'(64'd1048576);
			default: r = ZW'(64'd1 << (30 - i));
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/savb_isqrt.sv =====
// ----------------------------------------------------------------------------
// savb_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module savb_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        in_vld,
	input  wire logic [savb_pkg::SQW-1:0]    in_val,
	input  savb_pkg::sqrt_side_t             in_side,
	output logic                             out_vld,
	output logic [savb_pkg::RW-1:0]          out_root,
	output savb_pkg::sqrt_side_t             out_side
);
	import savb_pkg::*;

	logic [SQW-1:0] v_q    [SQ_STEPS];
	logic [SQW-1:0] r_q    [SQ_STEPS];
	logic           vld_q  [SQ_STEPS];
	sqrt_side_t     side_q [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
		localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
		logic [SQW-1:0] vi, ri, trial, vn, rn;
		logic           vli;
		sqrt_side_t     si;
		if (k == 0) begin : g_in
			assign vi  = in_val;
			assign ri  = '0;
			assign vli = in_vld;
			assign si  = in_side;
		end else begin : g_mid
			assign vi  = v_q[k-1];
			assign ri  = r_q[k-1];
			assign vli = vld_q[k-1];
			assign si  = side_q[k-1];
		end
		always_comb begin
			trial = ri + BIT;
			if (vi >= trial) begin
				vn = vi - trial;
				rn = (ri >> 1) + BIT;
			end else begin
				vn = vi;
				rn = ri >> 1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv) begin
				vld_q[k] <= vli;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				v_q[k]    <= vn;
				r_q[k]    <= rn;
				side_q[k] <= si;
			end
		end
	end

	assign out_vld  = vld_q[SQ_STEPS-1];
	assign out_root = r_q[SQ_STEPS-1][RW-1:0];
	assign out_side = side_q[SQ_STEPS-1];
endmodule
`default_nettype wire

// ===== design/savb_cordic.sv =====
// ----------------------------------------------------------------------------
// savb_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 with left half-plane fold.
// ----------------------------------------------------------------------------
`default_nettype none
module savb_cordic (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          in_vld,
	input  wire logic signed [savb_pkg::CXW-1:0] in_x,
	input  wire logic signed [savb_pkg::CXW-1:0] in_y,
	input  savb_pkg::flags_t                   in_flags,
	output logic                               out_vld,
	output logic signed [savb_pkg::ZW-1:0]     out_z,
	output savb_pkg::flags_t                   out_flags
);
	import savb_pkg::*;

	localparam int N = CORDIC_STEPS + 1;

	logic signed [CXW-1:0] x_q [N];
	logic signed [CXW-1:0] y_q [N];
	logic signed [ZW-1:0]  z_q [N];
	logic                  vld_q [N];
	flags_t                fl_q  [N];

	// fold stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fl_q[0] <= in_flags;
			if (in_x < 0) begin
				x_q[0] <= in_y;
				y_q[0] <= -in_x;
				z_q[0] <= HALF_PI_Q30;
			end else begin
				x_q[0] <= in_x;
				y_q[0] <= in_y;
				z_q[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k < N; k++) begin : g_it
		localparam logic signed [ZW-1:0] ARC = arc_step(k - 1);
		logic signed [CXW-1:0] dx, dy;
		assign dx = x_q[k-1] >>> (k - 1);
		assign dy = y_q[k-1] >>> (k - 1);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				fl_q[k] <= fl_q[k-1];
				if (y_q[k-1] >= 0) begin
					x_q[k] <= x_q[k-1] + dy;
					y_q[k] <= y_q[k-1] - dx;
					z_q[k] <= z_q[k-1] + ARC;
				end else begin
					x_q[k] <= x_q[k-1] - dy;
					y_q[k] <= y_q[k-1] + dx;
					z_q[k] <= z_q[k-1] - ARC;
				end
			end
		end
	end

	assign out_vld   = vld_q[N-1];
	assign out_z     = z_q[N-1];
	assign out_flags = fl_q[N-1];
endmodule
`default_nettype wire

// ===== design/signed_angle_between_vectors_core.sv =====
// ----------------------------------------------------------------------------
// signed_angle_between_vectors_core
// Signed angle between two 3D vectors, sign set by a reference normal.
// ----------------------------------------------------------------------------
// Input channel s_*: one item = first, second and normal vectors, nine signed
// 16-bit components packed x,y,z first/second/normal from bit 0 up.
// Output channel m_*: m_tdata holds the angle in signed Q3.13 radians,
// m_tuser is the degenerate flag (a zero vector; angle is then +pi/2).
// Path from input accept to output valid: 6 product and normalize stages,
// 31 square-root stages, 31 CORDIC stages, 1 output stage. Throughput:
// one item per cycle unless the output stalls; every stage is registered.
// All stages advance together when the output register is empty or taken,
// so s_tready is low only while a result waits and m_tready is low; items
// then hold in place, nothing is dropped or repeated.
// Reset clears every valid bit; the pipeline starts empty.
// ----------------------------------------------------------------------------
`default_nettype none
module signed_angle_between_vectors_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [savb_pkg::IN_TW-1:0]    s_tdata,  // first_x,y,z, second_x,y,z, normal_x,y,z
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [savb_pkg::OUT_TW-1:0]        m_tdata,  // angle
	output logic                               m_tuser   // degenerate
);
	import savb_pkg::*;

	logic adv;
	logic out_vld_q;
	logic [AW-1:0] angle_q;
	logic degen_q;

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;

	logic signed [CW-1:0] a [3];
	logic signed [CW-1:0] b [3];
	logic signed [CW-1:0] n [3];
	for (genvar i = 0; i < 3; i++) begin : g_unp
		assign a[i] = s_tdata[CW*i +: CW];
		assign b[i] = s_tdata[CW*(3+i) +: CW];
		assign n[i] = s_tdata[CW*(6+i) +: CW];
	end

	// s1: products
	logic                 vld_s1;
	logic signed [PW-1:0] pc_s1 [6];
	logic signed [PW-1:0] pd_s1 [3];
	logic signed [CW-1:0] n_s1  [3];
	logic                 degen_s1;

	// s2: cross and dot
	logic                 vld_s2;
	logic signed [XW-1:0] c_s2 [3];
	logic signed [DW-1:0] dot_s2;
	logic signed [CW-1:0] n_s2 [3];
	logic                 degen_s2;

	// s3: triple terms and magnitudes
	logic                  vld_s3;
	logic signed [TPW-1:0] tp_s3 [3];
	logic [MW-1:0]         cm_s3 [3];
	logic [MW-1:0]         dm_s3;
	logic                  dneg_s3, degen_s3;

	// s4: sign and normalization
	logic                  vld_s4;
	logic [NW-1:0]         cn_s4 [3];
	logic signed [CXW-1:0] x_s4;
	flags_t                fl_s4;

	// s5: squares
	logic                  vld_s5;
	logic [2*NW-1:0]       sq_s5 [3];
	logic signed [CXW-1:0] x_s5;
	flags_t                fl_s5;

	// s6: sum of squares
	logic                  vld_s6;
	logic [SQW-1:0]        sum_s6;
	logic signed [CXW-1:0] x_s6;
	flags_t                fl_s6;

	logic signed [TW-1:0] trip;
	logic [MW-1:0]        mx;
	logic [SHW-1:0]       sft;

	always_comb begin
		trip = TW'(tp_s3[0]) + TW'(tp_s3[1]) + TW'(tp_s3[2]);
		mx = dm_s3;
		for (int i = 0; i < 3; i++) begin
			if (cm_s3[i] > mx) mx = cm_s3[i];
		end
		sft = '0;
		for (int j = 1; j <= MW - NW; j++) begin
			if ((mx >> (NW + j - 1)) != '0) sft = SHW'(j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s1[0] <= a[1] * b[2];
			pc_s1[1] <= a[2] * b[1];
			pc_s1[2] <= a[2] * b[0];
			pc_s1[3] <= a[0] * b[2];
			pc_s1[4] <= a[0] * b[1];
			pc_s1[5] <= a[1] * b[0];
			for (int i = 0; i < 3; i++) begin
				pd_s1[i] <= a[i] * b[i];
				n_s1[i]  <= n[i];
			end
			degen_s1 <= (a[0] == '0 && a[1] == '0 && a[2] == '0) ||
			            (b[0] == '0 && b[1] == '0 && b[2] == '0);

			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= XW'(pc_s1[2*i]) - XW'(pc_s1[2*i+1]);
				n_s2[i] <= n_s1[i];
			end
			dot_s2   <= DW'(pd_s1[0]) + DW'(pd_s1[1]) + DW'(pd_s1[2]);
			degen_s2 <= degen_s1;

			for (int i = 0; i < 3; i++) begin
				tp_s3[i] <= n_s2[i] * c_s2[i];
				cm_s3[i] <= c_s2[i][XW-1] ? MW'(-c_s2[i]) : MW'(c_s2[i]);
			end
			dm_s3    <= dot_s2[DW-1] ? MW'(-dot_s2) : MW'(dot_s2);
			dneg_s3  <= dot_s2[DW-1];
			degen_s3 <= degen_s2;

			for (int i = 0; i < 3; i++) begin
				cn_s4[i] <= NW'(cm_s3[i] >> sft);
			end
			x_s4 <= dneg_s3 ? -$signed(CXW'(dm_s3 >> sft)) : $signed(CXW'(dm_s3 >> sft));
			fl_s4.neg   <= trip[TW-1];
			fl_s4.degen <= degen_s3;

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= cn_s4[i] * cn_s4[i];
			end
			x_s5  <= x_s4;
			fl_s5 <= fl_s4;

			sum_s6 <= SQW'(sq_s5[0]) + SQW'(sq_s5[1]) + SQW'(sq_s5[2]);
			x_s6   <= x_s5;
			fl_s6  <= fl_s5;
		end
	end

	logic          sq_vld;
	logic [RW-1:0] sq_root;
	sqrt_side_t    sq_side_in, sq_side;

	assign sq_side_in.flags = fl_s6;
	assign sq_side_in.x     = x_s6;

	savb_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s6),
		.in_val   (sum_s6),
		.in_side  (sq_side_in),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	logic                 co_vld;
	logic signed [ZW-1:0] co_z;
	flags_t               co_fl;

	savb_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (sq_vld),
		.in_x      (sq_side.x),
		.in_y      ($signed(CXW'(sq_root))),
		.in_flags  (sq_side.flags),
		.out_vld   (co_vld),
		.out_z     (co_z),
		.out_flags (co_fl)
	);

	logic signed [ZW-1:0] zc, zr;
	logic [AW-1:0]        mag;

	always_comb begin
		if (co_z < 0) begin
			zc = '0;
		end else if (co_z > PI_Q30) begin
			zc = PI_Q30;
		end else begin
			zc = co_z;
		end
		zr  = zc + RND_Q30;
		mag = AW'(zr >>> SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= co_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_q <= co_fl.degen;
			if (co_fl.degen) begin
				angle_q <= HALF_PI_ANGLE;
			end else if (co_fl.neg) begin
				angle_q <= AW'(0) - mag;
			end else begin
				angle_q <= mag;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_TW'(angle_q);
	assign m_tuser  = degen_q;

`ifndef ASSERT_OFF
	a_degen_angle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[AW-1:0] == HALF_PI_ANGLE)
		else $error("degenerate item without +pi/2 angle");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[AW-1:0]) <= $signed(PI_ANGLE) &&
		             $signed(m_tdata[AW-1:0]) >= -$signed(PI_ANGLE))
		else $error("angle outside -pi..pi");
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");
`endif
endmodule
`default_nettype wire
